// ===== rtl/core/sct_pkg.sv =====
package sct_pkg;

    localparam int NUM_TERMS = 7;
    localparam int QUOT_W    = 33;
    localparam int TMAG_W    = 33;
    localparam int RED_MAG_W = 34;

    // Q.32 angle constants, rounded to nearest
    localparam logic [34:0] PI_HALF_Q32 = 35'h1_921F_B544;
    localparam logic [34:0] PI_Q32      = 35'h3_243F_6A89;
    localparam logic [34:0] TWO_PI_Q32  = 35'h6_487E_D511;

    localparam logic [TMAG_W-1:0] ONE_Q30 = TMAG_W'(33'h0_4000_0000);

    // innermost term first
    localparam logic [0:NUM_TERMS-1][7:0] SERIES_DIV = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };

    // floor(2^35 / d) for the divide-by-constant in the quotient stages
    localparam logic [0:NUM_TERMS-1][34:0] SERIES_RECIP = '{
        35'((64'd1 << 35) / 64'd182),
        35'((64'd1 << 35) / 64'd132),
        35'((64'd1 << 35) / 64'd90),
        35'((64'd1 << 35) / 64'd56),
        35'((64'd1 << 35) / 64'd30),
        35'((64'd1 << 35) / 64'd12),
        35'((64'd1 << 35) / 64'd2)
    };

    typedef logic [0:NUM_TERMS-1][QUOT_W-1:0] sct_quot_vec_t;

    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic [RED_MAG_W-1:0] mag;
    } sct_red_t;

    typedef struct packed {
        logic          valid;
        logic          neg;
        sct_quot_vec_t quot;
    } sct_quot_t;

    typedef struct packed {
        logic              valid;
        logic              neg;
        logic              sign;
        logic [TMAG_W-1:0] mag;
    } sct_term_t;

endpackage

// ===== rtl/core/sct_reduce.sv =====
module sct_reduce #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic signed [31:0]  angle,
    output sct_pkg::sct_red_t   red,
    input  logic                red_ready
);

    localparam int MAG_W     = 64 - ANGLE_FRAC_BITS;
    localparam int X_W       = MAG_W + 1;
    localparam int ANG_SHIFT = 32 - ANGLE_FRAC_BITS;
    localparam int NRED      = MAG_W - 34;
    localparam int NST       = NRED + 3;
    localparam int RED_W     = sct_pkg::RED_MAG_W;

    logic [NST-1:0]         vld_reg;
    logic [NST-1:0]         vin;
    logic [NST-1:0]         en;
    logic signed [X_W-1:0]  x_reg;
    logic signed [X_W-1:0]  x_next;
    logic [MAG_W-1:0]       mag_reg;
    logic [MAG_W-1:0]       mag_next;
    logic [MAG_W-1:0]       rem_in [NRED];
    logic [MAG_W-1:0]       rem_reg [NRED];
    logic [RED_W:0]         fold_src;
    logic [RED_W-1:0]       fold_mag_reg;
    logic [RED_W-1:0]       fold_mag_next;
    logic                   fold_neg_reg;
    logic                   fold_neg_next;

    assign vin = {vld_reg[NST-2:0], in_valid};

    // a stage may load when red_ready is high or when it or any stage after it is empty
    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            en[i] = red_ready || (((~vld_reg) >> i) != '0);
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vin[i];
            end
        end
    end

    always_comb
    begin
        x_next = (X_W'(angle) <<< ANG_SHIFT)
               - (op ? X_W'(sct_pkg::PI_HALF_Q32) : X_W'(0));
        mag_next = x_reg[X_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
    end

    // restoring reduction by 2*pi, one quotient bit per stage
    for (genvar j = 0; j < NRED; j++)
    begin : g_rem
        localparam logic [MAG_W-1:0] STEP = MAG_W'(sct_pkg::TWO_PI_Q32) << (NRED - 1 - j);
        logic [MAG_W-1:0] rem_next;

        if (j == 0)
        begin : g_first
            assign rem_in[j] = mag_reg;
        end
        else
        begin : g_chain
            assign rem_in[j] = rem_reg[j-1];
        end

        assign rem_next = (rem_in[j] >= STEP) ? rem_in[j] - STEP : rem_in[j];

        always_ff @(posedge clk)
        begin
            if (en[j+2])
                rem_reg[j] <= rem_next;
        end
    end

    always_comb
    begin
        fold_src      = rem_reg[NRED-1][RED_W:0];
        fold_neg_next = fold_src >= sct_pkg::PI_Q32;
        fold_mag_next = fold_neg_next ? RED_W'(fold_src - sct_pkg::PI_Q32)
                                      : fold_src[RED_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            x_reg <= x_next;
        if (en[1])
            mag_reg <= mag_next;
        if (en[NST-1])
        begin
            fold_mag_reg <= fold_mag_next;
            fold_neg_reg <= fold_neg_next;
        end
    end

    assign red.valid = vld_reg[NST-1];
    assign red.neg   = fold_neg_reg;
    assign red.mag   = fold_mag_reg;

    a_fold_below_pi: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] |-> fold_mag_reg < RED_W'(sct_pkg::PI_Q32))
        else $error("reduced angle not below pi");

endmodule

// ===== rtl/core/sct_square.sv =====
module sct_square (
    input  logic               clk,
    input  logic               rst_n,
    input  sct_pkg::sct_red_t  red,
    output logic               red_ready,
    output sct_pkg::sct_quot_t quot,
    input  logic               quot_ready
);

    localparam int NST = 5;
    localparam int NT  = sct_pkg::NUM_TERMS;
    localparam int QW  = sct_pkg::QUOT_W;
    localparam int N_W = 35;
    localparam int P_W = 70;
    localparam int Y_W = 34;

    logic [NST-1:0]         vld_reg;
    logic [NST-1:0]         neg_reg;
    logic [NST-1:0]         vin;
    logic [NST-1:0]         nin;
    logic [NST-1:0]         en;
    logic [31:0]            x30_reg;
    logic [31:0]            x30_next;
    logic [63:0]            sq_reg;
    logic [63:0]            sq_next;
    logic [Y_W-1:0]         y_reg;
    logic [Y_W-1:0]         y_next;
    logic [N_W-1:0]         n_reg [NT];
    logic [N_W-1:0]         n_next [NT];
    logic [P_W-1:0]         prod_reg [NT];
    logic [P_W-1:0]         prod_next [NT];
    logic [N_W-1:0]         q0 [NT];
    logic [N_W-1:0]         qd [NT];
    logic [N_W-1:0]         rm [NT];
    sct_pkg::sct_quot_vec_t quot_reg;
    sct_pkg::sct_quot_vec_t quot_next;

    assign vin = {vld_reg[NST-2:0], red.valid};
    assign nin = {neg_reg[NST-2:0], red.neg};

    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            en[i] = quot_ready || (((~vld_reg) >> i) != '0);
        end
    end

    assign red_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vin[i];
            end
        end
    end

    always_comb
    begin
        x30_next = 32'((35'(red.mag) + 35'd2) >> 2);
        sq_next  = 64'(x30_reg) * 64'(x30_reg);
        y_next   = Y_W'((sq_reg + 64'h2000_0000) >> 30);
        for (int i = 0; i < NT; i++)
        begin
            n_next[i]    = N_W'(y_reg) + N_W'(sct_pkg::SERIES_DIV[i] >> 1);
            prod_next[i] = P_W'(n_next[i]) * P_W'(sct_pkg::SERIES_RECIP[i]);
            // estimate is exact or one low; fix with the remainder
            q0[i] = prod_reg[i][P_W-1:35];
            qd[i] = q0[i] * N_W'(sct_pkg::SERIES_DIV[i]);
            rm[i] = n_reg[i] - qd[i];
            quot_next[i] = (rm[i] >= N_W'(sct_pkg::SERIES_DIV[i])) ? QW'(q0[i] + N_W'(1))
                                                                  : QW'(q0[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NST; i++)
        begin
            if (en[i])
                neg_reg[i] <= nin[i];
        end
        if (en[0])
            x30_reg <= x30_next;
        if (en[1])
            sq_reg <= sq_next;
        if (en[2])
            y_reg <= y_next;
        if (en[3])
        begin
            for (int i = 0; i < NT; i++)
            begin
                n_reg[i]    <= n_next[i];
                prod_reg[i] <= prod_next[i];
            end
        end
        if (en[4])
            quot_reg <= quot_next;
    end

    assign quot.valid = vld_reg[NST-1];
    assign quot.neg   = neg_reg[NST-1];
    assign quot.quot  = quot_reg;

    a_quot_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] |-> quot_reg[0] <= quot_reg[NT-1])
        else $error("series quotients out of order");

endmodule

// ===== rtl/core/sct_series.sv =====
module sct_series (
    input  logic               clk,
    input  logic               rst_n,
    input  sct_pkg::sct_quot_t quot,
    output logic               quot_ready,
    output sct_pkg::sct_term_t term,
    input  logic               term_ready
);

    localparam int NT  = sct_pkg::NUM_TERMS;
    localparam int NST = 2 * NT;
    localparam int QW  = sct_pkg::QUOT_W;
    localparam int TW  = sct_pkg::TMAG_W;
    localparam int PW  = QW + TW;
    localparam int RW  = PW - 30;
    localparam logic [RW-1:0] ONE_R     = RW'(sct_pkg::ONE_Q30);
    localparam logic [PW-1:0] HALF_P    = PW'(1) << 29;
    localparam logic [TW-1:0] MAG_LIMIT = TW'(1) << 31;

    logic [NST-1:0]         vld_reg;
    logic [NST-1:0]         vin;
    logic [NST-1:0]         en;

    logic [TW-1:0]          a_mag_in [NT];
    logic                   a_sgn_in [NT];
    logic                   a_neg_in [NT];
    sct_pkg::sct_quot_vec_t a_quot_in [NT];

    logic [PW-1:0]          prod_reg [NT];
    logic                   a_sgn_reg [NT];
    logic                   a_neg_reg [NT];
    sct_pkg::sct_quot_vec_t a_quot_reg [NT];

    logic [TW-1:0]          t_mag_reg [NT];
    logic                   t_sgn_reg [NT];
    logic                   b_neg_reg [NT];
    sct_pkg::sct_quot_vec_t b_quot_reg [NT];

    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            vin[i] = (i == 0) ? quot.valid : vld_reg[(i == 0) ? 0 : i - 1];
            en[i]  = term_ready || (((~vld_reg) >> i) != '0);
        end
    end

    assign quot_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NST; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vin[i];
            end
        end
    end

    // term i: multiply stage, then round and t = 1 - (y/d)*t
    for (genvar i = 0; i < NT; i++)
    begin : g_term
        logic [PW-1:0] prod_next;
        logic [RW-1:0] rnd;
        logic [TW-1:0] mag_next;
        logic          sgn_next;

        if (i == 0)
        begin : g_first
            assign a_mag_in[i]  = sct_pkg::ONE_Q30;
            assign a_sgn_in[i]  = 1'b0;
            assign a_neg_in[i]  = quot.neg;
            assign a_quot_in[i] = quot.quot;
        end
        else
        begin : g_chain
            assign a_mag_in[i]  = t_mag_reg[i-1];
            assign a_sgn_in[i]  = t_sgn_reg[i-1];
            assign a_neg_in[i]  = b_neg_reg[i-1];
            assign a_quot_in[i] = b_quot_reg[i-1];
        end

        assign prod_next = PW'(a_quot_in[i][i]) * PW'(a_mag_in[i]);

        always_comb
        begin
            rnd = RW'((prod_reg[i] + HALF_P) >> 30);
            if (a_sgn_reg[i])
            begin
                mag_next = TW'(ONE_R + rnd);
                sgn_next = 1'b0;
            end
            else if (rnd > ONE_R)
            begin
                mag_next = TW'(rnd - ONE_R);
                sgn_next = 1'b1;
            end
            else
            begin
                mag_next = TW'(ONE_R - rnd);
                sgn_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[2*i])
            begin
                prod_reg[i]   <= prod_next;
                a_sgn_reg[i]  <= a_sgn_in[i];
                a_neg_reg[i]  <= a_neg_in[i];
                a_quot_reg[i] <= a_quot_in[i];
            end
            if (en[2*i+1])
            begin
                t_mag_reg[i]  <= mag_next;
                t_sgn_reg[i]  <= sgn_next;
                b_neg_reg[i]  <= a_neg_reg[i];
                b_quot_reg[i] <= a_quot_reg[i];
            end
        end
    end

    assign term.valid = vld_reg[NST-1];
    assign term.neg   = b_neg_reg[NT-1];
    assign term.sign  = t_sgn_reg[NT-1];
    assign term.mag   = t_mag_reg[NT-1];

    a_term_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[NST-1] |-> t_mag_reg[NT-1] < MAG_LIMIT)
        else $error("series result magnitude out of range");

endmodule

// ===== rtl/core/sine_cosine_taylor_fixed_top.sv =====
// Fixed-point cosine/sine: 2*pi range reduction, squaring, nested Taylor series.
// Pipeline: 30 - ANGLE_FRAC_BITS restoring 2*pi reduction stages plus 24 fixed stages.
// Throughput: one item per cycle while out_ready is not held low; each stage has its own valid
//   bit and bubbles are squeezed out.
// Reset: rst_n asynchronously clears every valid bit; data registers are not reset.
module sine_cosine_taylor_fixed_top #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value
);

    localparam int SHIFT = 30 - RESULT_FRAC_BITS;
    localparam int TW    = sct_pkg::TMAG_W;
    localparam int RM_W  = TW + 1;
    localparam logic [RM_W-1:0] SAT_POS = RM_W'(32'h7FFF_FFFF);
    localparam logic [RM_W-1:0] SAT_NEG = RM_W'(32'h8000_0000);

    sct_pkg::sct_red_t  red;
    logic               red_ready;
    sct_pkg::sct_quot_t quot;
    logic               quot_ready;
    sct_pkg::sct_term_t term;
    logic               term_ready;

    logic               en_r;
    logic               en_out;
    logic               r_vld_reg;
    logic               out_vld_reg;
    logic [RM_W-1:0]    rm_reg;
    logic [RM_W-1:0]    rm_next;
    logic               rneg_reg;
    logic               rneg_next;
    logic [RM_W-1:0]    sat_mag;
    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    sct_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .angle    (angle),
        .red      (red),
        .red_ready(red_ready)
    );

    sct_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .red       (red),
        .red_ready (red_ready),
        .quot      (quot),
        .quot_ready(quot_ready)
    );

    sct_series u_series (
        .clk       (clk),
        .rst_n     (rst_n),
        .quot      (quot),
        .quot_ready(quot_ready),
        .term      (term),
        .term_ready(term_ready)
    );

    assign en_out     = !out_vld_reg || out_ready;
    assign en_r       = !r_vld_reg || en_out;
    assign term_ready = en_r;

    if (SHIFT > 0)
    begin : g_round
        localparam logic [RM_W-1:0] HALF = RM_W'(1) << (SHIFT - 1);
        assign rm_next = (RM_W'(term.mag) + HALF) >> SHIFT;
    end
    else
    begin : g_noround
        assign rm_next = RM_W'(term.mag);
    end

    // negative only for a nonzero magnitude
    assign rneg_next = (term.mag != '0) && (term.sign ^ term.neg);

    always_comb
    begin
        if (rneg_reg)
            sat_mag = (rm_reg > SAT_NEG) ? SAT_NEG : rm_reg;
        else
            sat_mag = (rm_reg > SAT_POS) ? SAT_POS : rm_reg;
        value_next = rneg_reg ? 32'(RM_W'(0) - sat_mag) : 32'(sat_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en_r)
                r_vld_reg <= term.valid;
            if (en_out)
                out_vld_reg <= r_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_r)
        begin
            rm_reg   <= rm_next;
            rneg_reg <= rneg_next;
        end
        if (en_out)
            value_reg <= value_next;
    end

    assign out_valid = out_vld_reg;
    assign value     = value_reg;

    a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input blocked while the output is not stalled");

    a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !r_vld_reg |=> !out_valid)
        else $error("output valid without a pending item");

endmodule
